// ===== hw/rtl/see_pkg.sv =====
// ============================================================================
// see_pkg
// Shared types and constants for the stack expression evaluator.
// ============================================================================
package see_pkg;

    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int RESULT_WIDTH = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_CARET = 8'h5e;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_BAD   = 3'd4,
        ST_LEFT  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_REM,
        OP_POW
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_READ1,
        S_READ2,
        S_EXEC,
        S_WAIT,
        S_WRITE,
        S_FINAL_READ,
        S_FINAL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [7:0] token;
        logic       last_token;
    } in_item_t;

    typedef struct packed {
        logic signed [RESULT_WIDTH-1:0] result_value;
        logic [2:0]                     status;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic push_digit;
        logic read_top;
        logic read_second;
        logic start_op;
        logic write_result;
        logic read_final;
        logic capture_out;
        logic clear_expr;
        logic note_valid;
        status_t note_code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_digit;
        logic is_op;
        logic last;
        logic full;
        logic lt_two;
        logic empty;
        logic more_than_one;
        logic op_done;
        logic div_zero;
    } dp_status_t;

endpackage

// ===== hw/rtl/stack_expression_evaluator_core.sv =====
// ============================================================================
// stack_expression_evaluator_core
// Postfix/prefix expression evaluator over a character token stream.
// ============================================================================
// Input channel in_valid/in_ready carries one token and a last flag per
// transaction; output channel out_valid/out_ready carries the result value
// and status of an expression, one transaction per last token.
// eval_mode_we/eval_mode_wdata set operand order (0 postfix, 1 prefix);
// write only while idle.
// One token is worked at a time; divide, remainder and power run in the
// iterative divider and the square-and-multiply loop of the arithmetic
// unit. A last token also reads the stack top and builds the result.
// The result holds in the output register while out_ready is low, and no
// token is taken until it is delivered. Reset empties the stack, clears
// the status and sets postfix order; stack contents are not cleared.
// ============================================================================
module stack_expression_evaluator_core
    import see_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      eval_mode_we,
    input  logic      eval_mode_wdata,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic       eval_mode_reg;
    dp_cmd_t    cmd;
    dp_status_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eval_mode_reg <= 1'b0;
        else if (eval_mode_we)
            eval_mode_reg <= eval_mode_wdata;
    end

    see_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    see_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .eval_mode (eval_mode_reg),
        .in_item   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_data)
    );

endmodule

// ===== hw/rtl/see_alu.sv =====
// ============================================================================
// see_alu
// Multi-cycle arithmetic unit: add, subtract, multiply, restoring divide,
// and square-and-multiply power, one step per cycle.
// ============================================================================
module see_alu
    import see_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  op_t                    op,
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);
    localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] ALL1 = '1;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_POW_M,
        A_POW_S,
        A_DONE
    } alu_state_t;

    alu_state_t             st_reg, st_next;
    op_t                    op_reg;
    logic [VALUE_WIDTH-1:0] x_reg, x_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   qneg_reg, rneg_reg;
    logic [VALUE_WIDTH-1:0] mag_a, mag_b;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] prod;

    assign mag_a = a[VALUE_WIDTH-1] ? (~a + ONE) : a;
    assign mag_b = b[VALUE_WIDTH-1] ? (~b + ONE) : b;
    assign prod  = VALUE_WIDTH'(x_reg * y_reg);
    assign trial = {rem_reg, acc_reg[VALUE_WIDTH-1]} - {1'b0, y_reg};

    always_comb
    begin
        st_next  = st_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    x_next = a;
                    y_next = b;
                    st_next = A_DONE;
                    case (op)
                        OP_ADD: acc_next = a + b;
                        OP_SUB: acc_next = a - b;
                        OP_MUL: st_next = A_MUL;
                        OP_DIV, OP_REM:
                        begin
                            acc_next = mag_a;
                            y_next   = mag_b;
                            rem_next = '0;
                            cnt_next = CW'(VALUE_WIDTH);
                            if (b == '0)
                                acc_next = '0;
                            else
                                st_next = A_DIV;
                        end
                        OP_POW:
                        begin
                            acc_next = ONE;
                            if (b[VALUE_WIDTH-1])
                            begin
                                if (a == ONE)
                                    acc_next = ONE;
                                else if (a == ALL1)
                                    acc_next = b[0] ? ALL1 : ONE;
                                else
                                    acc_next = '0;
                            end
                            else if (b != '0)
                                st_next = A_POW_M;
                        end
                        default: acc_next = '0;
                    endcase
                end
            end
            A_MUL:
            begin
                acc_next = prod;
                st_next  = A_DONE;
            end
            A_DIV:
            begin
                acc_next = {acc_reg[VALUE_WIDTH-2:0], ~trial[VALUE_WIDTH]};
                if (trial[VALUE_WIDTH])
                    rem_next = {rem_reg[VALUE_WIDTH-2:0], acc_reg[VALUE_WIDTH-1]};
                else
                    rem_next = trial[VALUE_WIDTH-1:0];
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    st_next = A_DONE;
            end
            A_POW_M:
            begin
                // acc *= base when exponent bit set
                if (y_reg[0])
                    acc_next = VALUE_WIDTH'(acc_reg * x_reg);
                st_next = A_POW_S;
            end
            A_POW_S:
            begin
                x_next = VALUE_WIDTH'(x_reg * x_reg);
                y_next = y_reg >> 1;
                if ((y_reg >> 1) == '0)
                    st_next = A_DONE;
                else
                    st_next = A_POW_M;
            end
            A_DONE:   st_next = A_IDLE;
            default:  st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= A_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (st_reg == A_IDLE && start)
        begin
            op_reg   <= op;
            qneg_reg <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
            rneg_reg <= a[VALUE_WIDTH-1];
        end
    end

    assign done = (st_reg == A_DONE);

    always_comb
    begin
        case (op_reg)
            OP_DIV:  result = qneg_reg ? (~acc_reg + ONE) : acc_reg;
            OP_REM:  result = rneg_reg ? (~rem_reg + ONE) : rem_reg;
            default: result = acc_reg;
        endcase
    end

endmodule

// ===== hw/rtl/see_datapath.sv =====
// ============================================================================
// see_datapath
// Operand stack memory, stack pointer, sticky status and arithmetic unit.
// ============================================================================
module see_datapath
    import see_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        eval_mode,
    input  in_item_t    in_item,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    output out_item_t   out_item
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [VALUE_WIDTH-1:0] mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic [VALUE_WIDTH-1:0] first_reg, second_reg;
    logic [CW-1:0]          count_reg, count_next;
    status_t                err_reg, err_next;
    in_item_t               item_reg;
    out_item_t              out_reg;
    op_t                    op;
    logic                   alu_done;
    logic [VALUE_WIDTH-1:0] alu_result;
    logic [VALUE_WIDTH-1:0] opa, opb;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic                   rd_en;
    logic [VALUE_WIDTH-1:0] final_val;
    logic [RESULT_WIDTH-1:0] final_ext;

    always_comb
    begin
        case (item_reg.token)
            CHAR_PLUS:  op = OP_ADD;
            CHAR_MINUS: op = OP_SUB;
            CHAR_STAR:  op = OP_MUL;
            CHAR_SLASH: op = OP_DIV;
            CHAR_PCT:   op = OP_REM;
            default:    op = OP_POW;
        endcase
    end

    assign sts.is_digit = (item_reg.token >= CHAR_ZERO) && (item_reg.token <= CHAR_NINE);
    assign sts.is_op = (item_reg.token == CHAR_PLUS) || (item_reg.token == CHAR_MINUS)
        || (item_reg.token == CHAR_STAR) || (item_reg.token == CHAR_SLASH)
        || (item_reg.token == CHAR_PCT) || (item_reg.token == CHAR_CARET);
    assign sts.last = item_reg.last_token;
    assign sts.full = (count_reg >= CW'(STACK_DEPTH));
    assign sts.lt_two = (count_reg < CW'(2));
    assign sts.empty = (count_reg == '0);
    assign sts.more_than_one = (count_reg > CW'(1));
    assign sts.op_done = alu_done;
    assign sts.div_zero = (opb == '0) && (op == OP_DIV || op == OP_REM);

    assign opa = eval_mode ? first_reg : second_reg;
    assign opb = eval_mode ? second_reg : first_reg;

    see_alu #(.VALUE_WIDTH(VALUE_WIDTH)) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start_op),
        .op     (op),
        .a      (opa),
        .b      (opb),
        .done   (alu_done),
        .result (alu_result)
    );

    // stack memory ports
    assign wr_en   = cmd.push_digit || cmd.write_result;
    assign wr_addr = AW'(count_reg);
    assign wr_data = cmd.push_digit ? VALUE_WIDTH'(item_reg.token - CHAR_ZERO) : alu_result;
    assign rd_en   = cmd.read_top || cmd.read_second || cmd.read_final;
    assign rd_addr = cmd.read_second ? AW'(count_reg - CW'(2)) : AW'(count_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= in_item;
        if (cmd.read_second)
            first_reg <= rd_data_reg;
        if (cmd.capture_out)
            out_reg <= '{result_value: (err_next == ST_OK) ? final_ext : '0,
                         status: err_next};
    end

    // second operand is captured in the cycle after the first
    logic second_pending_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_pending_reg <= 1'b0;
        else
            second_pending_reg <= cmd.read_second;
    end
    always_ff @(posedge clk)
    begin
        if (second_pending_reg)
            second_reg <= rd_data_reg;
    end

    assign final_val = rd_data_reg;
    assign final_ext = RESULT_WIDTH'($signed(final_val));

    always_comb
    begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.note_valid && err_reg == ST_OK)
            err_next = cmd.note_code;
        if (cmd.push_digit || cmd.write_result)
            count_next = count_reg + CW'(1);
        else if (cmd.start_op)
            count_next = count_reg - CW'(2);
        if (cmd.clear_expr)
        begin
            count_next = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= ST_OK;
        end
        else if (cmd.clear_expr)
        begin
            count_reg <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    assign out_item = out_reg;

endmodule

// ===== hw/rtl/see_ctrl.sv =====
// ============================================================================
// see_ctrl
// Token sequencer: decode, stack reads, operation launch, final result.
// ============================================================================
module see_ctrl
    import see_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                if (sts.is_op && !sts.lt_two)
                    state_next = S_READ1;
                else if (sts.last)
                    state_next = S_FINAL_READ;
                else
                    state_next = S_IDLE;
            end
            S_READ1:      state_next = S_READ2;
            S_READ2:      state_next = S_EXEC;
            S_EXEC:       state_next = S_WAIT;
            S_WAIT:
                if (sts.op_done)
                    state_next = S_WRITE;
            S_WRITE:      state_next = sts.last ? S_FINAL_READ : S_IDLE;
            S_FINAL_READ: state_next = S_FINAL;
            S_FINAL:      state_next = S_OUT;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.note_code = ST_OK;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            S_DECODE:
            begin
                if (sts.is_digit)
                begin
                    if (sts.full)
                    begin
                        cmd.note_valid = 1'b1;
                        cmd.note_code  = ST_OVER;
                    end
                    else
                        cmd.push_digit = 1'b1;
                end
                else if (sts.is_op)
                begin
                    if (sts.lt_two)
                    begin
                        cmd.note_valid = 1'b1;
                        cmd.note_code  = ST_UNDER;
                    end
                    else
                        cmd.read_top = 1'b1;
                end
                else
                begin
                    cmd.note_valid = 1'b1;
                    cmd.note_code  = ST_BAD;
                end
            end
            S_READ1: cmd.read_second = 1'b1;
            S_EXEC:
            begin
                cmd.start_op   = 1'b1;
                cmd.note_valid = sts.div_zero;
                cmd.note_code  = ST_DIVZ;
            end
            S_WRITE: cmd.write_result = 1'b1;
            S_FINAL_READ: cmd.read_final = 1'b1;
            S_FINAL:
            begin
                cmd.capture_out = 1'b1;
                cmd.note_valid  = sts.empty || sts.more_than_one;
                cmd.note_code   = sts.empty ? ST_UNDER : ST_LEFT;
            end
            S_OUT:
            begin
                out_valid     = 1'b1;
                cmd.clear_expr = out_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== hw/rtl/see_checker.sv =====
// ============================================================================
// see_port_checker
// Port-level checks for the expression evaluator.
// ============================================================================
module see_port_checker
    import see_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("token taken while result pending");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status <= ST_LEFT)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.result_value == '0)
        else $error("nonzero value with error status");

endmodule

bind stack_expression_evaluator_core see_port_checker u_see_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
